// ===== hw/rtl/lcm_pkg.sv =====
`timescale 1ns / 1ps
package lcm_pkg;

  // 2^32 / (8*pi), rounded
  localparam logic [28:0] INV_8PI_Q32 = 29'd170891319;

  localparam int CHARGE_DIV = 8;

  // register indexes
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  // request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_DRAIN  = 1'b1;

  // read slots of the neighbor fetch
  localparam logic [2:0] RD_FR = 3'd0;
  localparam logic [2:0] RD_S  = 3'd1;
  localparam logic [2:0] RD_BR = 3'd2;
  localparam logic [2:0] RD_BC = 3'd3;
  localparam logic [2:0] RD_FC = 3'd4;

  // multiply steps: 0..11 cross terms, then three dot terms, then scaling
  localparam logic [3:0] STEP_DOT   = 4'd12;
  localparam logic [3:0] STEP_SCALE = 4'd15;

  // three Q1.15 components, x in the low bits
  typedef logic [2:0][15:0] vec_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  // cyclic successor of an axis, unused code folds to x
  function automatic logic [1:0] axis_next(input logic [1:0] a);
    logic [1:0] r;
    case (a)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] axis_fix(input logic [1:0] a);
    return (a == 2'd3) ? 2'd0 : a;
  endfunction

endpackage

// ===== hw/rtl/lcm_if.sv =====
`timescale 1ns / 1ps
// spin item channel
interface lcm_in_if #(parameter int SPIN_BITS = 16);
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic signed [SPIN_BITS-1:0] spin_x;
  logic signed [SPIN_BITS-1:0] spin_y;
  logic signed [SPIN_BITS-1:0] spin_z;
  modport source (output valid, req_type, spin_x, spin_y, spin_z, input ready);
  modport sink   (input valid, req_type, spin_x, spin_y, spin_z, output ready);
endinterface

// charge result channel
interface lcm_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] cell_row;
  logic        [7:0]  cell_col;
  logic signed [31:0] cell_charge;
  logic signed [47:0] running_total;
  logic               last_cell;
  modport source (output valid, cell_row, cell_col, cell_charge, running_total,
                  last_cell, input ready);
  modport sink   (input valid, cell_row, cell_col, cell_charge, running_total,
                  last_cell, output ready);
endinterface

// register write channel
interface lcm_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/lcm_line_store.sv =====
`timescale 1ns / 1ps
module lcm_line_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [47:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [47:0]   rdata_r
);

  logic [47:0] mem [DEPTH];

  // one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/lcm_mul.sv =====
`timescale 1ns / 1ps
module lcm_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [33:0] opa,
  input  logic signed [33:0] opb,
  output logic signed [67:0] prod_r
);

  // shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= opa * opb;
    end
  end

endmodule

// ===== hw/rtl/lattice_topological_charge_map.sv =====
`timescale 1ns / 1ps
// a sample that reports a cell and a drain each give one result once their reads and
// products are done; a sample on the first row skips both and only stores its spin
// ready only in idle: a new item waits until the last one finishes and its result loads
// the work per item is 16 products through one shared multiplier, each multiplied then
// accumulated, plus four or five reads through the single line store read port
// reset: synchronous active low, clears counters, total, sequencer, grid 16 x 16
module lattice_topological_charge_map
  import lcm_pkg::*;
#(
  parameter int MAX_COLS  = 256,
  parameter int SPIN_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lcm_in_if.sink    in_ch,
  lcm_out_if.source out_ch,
  lcm_cfg_if.sink   cfg_ch
);

  localparam int DEPTH   = 2 * MAX_COLS;
  localparam int AW      = $clog2(DEPTH);
  localparam int WW      = (AW > 9) ? AW : 9;
  localparam int COL_CAP = (MAX_COLS < 256) ? MAX_COLS : 256;

  state_t state_r, state_nxt;

  logic [15:0] grid_rows_r;
  logic [8:0]  grid_cols_r;
  logic [15:0] rows;
  logic [8:0]  cols;

  logic [15:0] in_row_r, out_row_r;
  logic [8:0]  in_col_r, out_col_r;

  // job registers
  logic [15:0] job_row_r;
  logic [8:0]  job_col_r;
  logic        need_emit_r, do_store_r;
  logic        fr_zero_r, br_zero_r, bc_zero_r, fc_zero_r, last_r;
  logic        st_par_r;
  logic [8:0]  st_col_r;
  vec_t        fr_r, s_r, br_r, bc_r, fc_r;

  logic [2:0]  rd_idx_r, cap_idx_r;
  logic        cap_vld_r;
  logic [3:0]  step_r;
  logic signed [33:0] w_r [3];
  logic signed [50:0] v_r;
  logic signed [31:0] charge_r;
  logic signed [47:0] total_r;
  logic signed [48:0] sum_total;
  logic signed [47:0] sat_total;

  // output register
  logic               out_valid_r;
  logic        [15:0] o_row_r;
  logic        [7:0]  o_col_r;
  logic signed [31:0] o_charge_r;
  logic signed [47:0] o_total_r;
  logic               o_last_r;

  function automatic logic [AW-1:0] st_addr(input logic par, input logic [8:0] col);
    logic [WW-1:0] w;
    w = WW'(col) + (par ? WW'(MAX_COLS) : WW'(0));
    return w[AW-1:0];
  endfunction

  function automatic logic [15:0] to_q15(input logic [SPIN_BITS-1:0] raw);
    logic [15:0] q;
    if (SPIN_BITS >= 16) begin
      q = 16'(raw >> (SPIN_BITS - 16));
    end else begin
      q = 16'({raw, 16'd0} >> SPIN_BITS);
    end
    return q;
  endfunction

  // effective grid size
  always_comb begin
    rows = (grid_rows_r == 16'd0) ? 16'd1 : grid_rows_r;
    cols = (grid_cols_r == 9'd0) ? 9'd1 : grid_cols_r;
    if (cols > 9'(COL_CAP)) begin
      cols = 9'(COL_CAP);
    end
  end

  // configuration port
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= 16'd16;
      grid_cols_r <= 9'd16;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_GRID_ROWS) begin
        grid_rows_r <= cfg_ch.data;
      end else begin
        grid_cols_r <= cfg_ch.data[8:0];
      end
    end
  end

  // counters normalized at the start of an item
  logic [15:0] ir_n, or_n;
  logic [8:0]  ic_n, oc_n;
  logic [15:0] em_row;
  logic [8:0]  em_col;
  logic [15:0] adv_row;
  logic [8:0]  adv_col;
  logic        accept, smp_go, drn_go, smp_emit;

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    ir_n = in_row_r;
    ic_n = in_col_r;
    if (in_col_r >= cols) begin
      ic_n = 9'd0;
      if (in_row_r < rows) ir_n = in_row_r + 16'd1;
    end
    or_n = out_row_r;
    oc_n = out_col_r;
    if (out_col_r >= cols) begin
      oc_n = 9'd0;
      if (out_row_r < rows) or_n = out_row_r + 16'd1;
    end
    smp_go   = (in_ch.req_type == REQ_SAMPLE) && (ir_n < rows);
    smp_emit = smp_go && (ir_n != 16'd0);
    drn_go   = (in_ch.req_type == REQ_DRAIN) && (ir_n >= rows) && (or_n < rows);
    em_row   = smp_go ? (ir_n - 16'd1) : or_n;
    em_col   = smp_go ? ic_n : oc_n;
    adv_row  = em_row;
    adv_col  = em_col + 9'd1;
    if (adv_col >= cols) begin
      adv_col = 9'd0;
      adv_row = em_row + 16'd1;
    end
  end

  // line store reads
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [47:0]   rd_data;
  logic          wr_en;
  logic          fin_go;

  always_comb begin
    rd_en   = (state_r == ST_READ) && (rd_idx_r <= RD_FC);
    case (rd_idx_r)
      RD_FR:   rd_addr = st_addr(~job_row_r[0], job_col_r);
      RD_S:    rd_addr = st_addr(job_row_r[0], job_col_r);
      RD_BR:   rd_addr = st_addr(~job_row_r[0], job_col_r);
      RD_BC:   rd_addr = st_addr(job_row_r[0], bc_zero_r ? 9'd0 : job_col_r - 9'd1);
      default: rd_addr = st_addr(job_row_r[0], fc_zero_r ? job_col_r : job_col_r + 9'd1);
    endcase
  end

  assign fin_go = (state_r == ST_FIN) && (!need_emit_r || !out_valid_r || out_ch.ready);
  assign wr_en  = fin_go && do_store_r;

  lcm_line_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (st_addr(st_par_r, st_col_r)),
    .wdata  (fr_r),
    .re     (rd_en),
    .raddr  (rd_addr),
    .rdata_r(rd_data)
  );

  // operand select for the shared multiplier
  logic signed [33:0] opa, opb;
  logic signed [67:0] prod;
  logic [1:0] ax_i, ax_j, ax_k, dot_i;
  vec_t       a_vec, b_vec;

  always_comb begin
    ax_i  = axis_fix(step_r[3:2]);
    ax_j  = axis_next(ax_i);
    ax_k  = axis_next(ax_j);
    dot_i = axis_fix(2'(step_r - STEP_DOT));
    a_vec = step_r[1] ? fr_r : br_r;
    b_vec = step_r[1] ? fc_r : bc_r;
    if (step_r < STEP_DOT) begin
      opa = 34'(signed'(step_r[0] ? a_vec[ax_k] : a_vec[ax_j]));
      opb = 34'(signed'(step_r[0] ? b_vec[ax_j] : b_vec[ax_k]));
    end else if (step_r < STEP_SCALE) begin
      opa = w_r[dot_i];
      opb = 34'(signed'(s_r[dot_i]));
    end else begin
      opa = v_r[49:16];
      opb = signed'(34'(INV_8PI_Q32));
    end
  end

  lcm_mul u_mul (
    .clk   (clk),
    .en    (state_r == ST_MUL),
    .opa   (opa),
    .opb   (opb),
    .prod_r(prod)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (smp_emit || drn_go) state_nxt = ST_READ;
          else if (smp_go)        state_nxt = ST_FIN;
        end
      end
      ST_READ: begin
        if (cap_vld_r && cap_idx_r == RD_FC) state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: state_nxt = (step_r == STEP_SCALE) ? ST_FIN : ST_MUL;
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // saturating running total
  always_comb begin
    sum_total = 49'(total_r) + 49'(charge_r);
    if (sum_total[48] != sum_total[47]) begin
      sat_total = sum_total[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      sat_total = sum_total[47:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_row_r    <= 16'd0;
      in_col_r    <= 9'd0;
      out_row_r   <= 16'd0;
      out_col_r   <= 9'd0;
      total_r     <= 48'sd0;
      out_valid_r <= 1'b0;
      cap_vld_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cap_vld_r <= rd_en;
      if (accept) begin
        if (smp_go) begin
          in_row_r <= ic_n + 9'd1 >= cols ? ir_n + 16'd1 : ir_n;
          in_col_r <= ic_n + 9'd1 >= cols ? 9'd0 : ic_n + 9'd1;
        end else begin
          in_row_r <= ir_n;
          in_col_r <= ic_n;
        end
        if (smp_emit || drn_go) begin
          out_row_r <= adv_row;
          out_col_r <= adv_col;
        end else begin
          out_row_r <= or_n;
          out_col_r <= oc_n;
        end
      end
      if (fin_go && need_emit_r) begin
        out_valid_r <= 1'b1;
        total_r     <= sat_total;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      job_row_r   <= em_row;
      job_col_r   <= em_col;
      need_emit_r <= smp_emit || drn_go;
      do_store_r  <= smp_go;
      st_par_r    <= ir_n[0];
      st_col_r    <= ic_n;
      fr_zero_r   <= !smp_go && ({1'b0, em_row} + 17'd1 >= {1'b0, rows});
      br_zero_r   <= (em_row == 16'd0);
      bc_zero_r   <= (em_col == 9'd0);
      fc_zero_r   <= (em_col + 9'd1 >= cols);
      last_r      <= ({1'b0, em_row} + 17'd1 == {1'b0, rows}) && (em_col + 9'd1 == cols);
      fr_r        <= {to_q15(in_ch.spin_z), to_q15(in_ch.spin_y), to_q15(in_ch.spin_x)};
      rd_idx_r    <= smp_go ? RD_S : RD_FR;
    end
    if (rd_en) begin
      rd_idx_r  <= rd_idx_r + 3'd1;
      cap_idx_r <= rd_idx_r;
    end
    // capture fetched neighbors, outside cells read as zero
    if (state_r == ST_READ && cap_vld_r) begin
      case (cap_idx_r)
        RD_FR:   fr_r <= fr_zero_r ? '0 : rd_data;
        RD_S:    s_r  <= rd_data;
        RD_BR:   br_r <= br_zero_r ? '0 : rd_data;
        RD_BC:   bc_r <= bc_zero_r ? '0 : rd_data;
        default: fc_r <= fc_zero_r ? '0 : rd_data;
      endcase
      if (cap_idx_r == RD_FC) begin
        step_r <= 4'd0;
        w_r[0] <= '0;
        w_r[1] <= '0;
        w_r[2] <= '0;
        v_r    <= '0;
      end
    end
    // accumulate the registered product
    if (state_r == ST_ACC) begin
      step_r <= step_r + 4'd1;
      if (step_r < STEP_DOT) begin
        if (step_r[0]) w_r[ax_i] <= w_r[ax_i] - 34'(signed'(prod[31:0]));
        else           w_r[ax_i] <= w_r[ax_i] + 34'(signed'(prod[31:0]));
      end else if (step_r < STEP_SCALE) begin
        v_r <= v_r + prod[50:0];
      end else begin
        charge_r <= prod[62:31];
      end
    end
    if (fin_go && need_emit_r) begin
      o_row_r    <= job_row_r;
      o_col_r    <= job_col_r[7:0];
      o_charge_r <= charge_r;
      o_total_r  <= sat_total;
      o_last_r   <= last_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cell_row      = o_row_r;
  assign out_ch.cell_col      = o_col_r;
  assign out_ch.cell_charge   = o_charge_r;
  assign out_ch.running_total = o_total_r;
  assign out_ch.last_cell     = o_last_r;

endmodule

// ===== hw/rtl/lcm_checker.sv =====
`timescale 1ns / 1ps
module lcm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_cell_charge,
  input logic signed [47:0] out_running_total
);

  // a result never appears right after an accept
  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result right after accept");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_charge) &&
    $stable(out_running_total))
    else $error("stalled result changed");

  // reset leaves no result and an idle sequencer
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // a new result only comes out of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

endmodule

bind lattice_topological_charge_map lcm_checker u_lcm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_cell_charge  (out_ch.cell_charge),
  .out_running_total(out_ch.running_total)
);
